[src/class_packet_scheduler_defines.svh]
// assertion macros for the class packet scheduler
`ifndef CLASS_PACKET_SCHEDULER_DEFINES_SVH
`define CLASS_PACKET_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define CPS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("scheduler assertion failed");
// property checked on every rising clock edge, reset included
`define CPS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("scheduler assertion failed");
`else
`define CPS_ASSERT(lbl, clk, rstn, prop)
`define CPS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[src/cps_pkg.sv]
package cps_pkg;

    localparam int NCLS   = 3;
    localparam int SIZE_W = 16;
    localparam int CLS_W  = 2;
    localparam int SRV_W  = 48;
    localparam int PROD_W = 56;
    localparam int OFF_W  = 57;

    localparam logic       OP_ENQ = 1'b0;
    localparam logic       OP_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    localparam logic [1:0] MODE_FIFO   = 2'd0;
    localparam logic [1:0] MODE_WFQ    = 2'd2;

    localparam logic [1:0] CLS_NONE    = 2'd3;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_LIMIT   = 3'd1;
    localparam logic [2:0] REG_W_AUDIO = 3'd2;
    localparam logic [2:0] REG_W_VIDEO = 3'd3;
    localparam logic [2:0] REG_W_DATA  = 3'd4;

    typedef struct packed {
        logic [CLS_W-1:0]  cls;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic             found;
        logic [CLS_W-1:0] q;
    } pick_t;

endpackage

[src/class_packet_scheduler.sv]
// channel | dir | handshake           | payload
// s_*     | in  | s_tvalid / s_tready | tuser: op; tdata: pkt_class, pkt_size
// m_*     | out | m_tvalid / m_tready | tuser: status; tdata: out_class, out_size
// cfg_*   | in  | cfg_we              | cfg_index, cfg_data
//
// an enqueue is captured, then checked and written to the packet store
// a dequeue runs offset multiply, pick, store read, update; a dequeue finding no packet ends at the pick
// the registered packet store read sets the dequeue length
// reset clears all queue pointers, counters and served totals; store needs no clearing
// a full result register stalls the finishing step, and no new transaction is taken until it completes
`include "class_packet_scheduler_defines.svh"

module class_packet_scheduler #(
    parameter int CLASS_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pkt_class[1:0], pkt_size[17:2], zero fill
    input  logic [0:0]  s_tuser,   // op[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_class[1:0], out_size[17:2], zero fill
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import cps_pkg::*;

    localparam int STORE = NCLS * CLASS_DEPTH;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(STORE + 1);
    localparam logic [AW-1:0] BASE1    = AW'(CLASS_DEPTH);
    localparam logic [AW-1:0] BASE2    = AW'(2 * CLASS_DEPTH);
    localparam logic [CW-1:0] CAP_FIFO = CW'(STORE);
    localparam logic [CW-1:0] CAP_CLS  = CW'(CLASS_DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_ENQ, S_MUL, S_PICK, S_DATA} state_t;

    // configuration
    logic [1:0]  mode_reg;
    logic [31:0] limit_reg;
    logic [31:0] limit3_reg;   // limit / 3 via reciprocal multiply
    logic [7:0]  weight_reg [NCLS];

    // per-queue state
    logic [AW-1:0]  head_reg [NCLS];
    logic [AW-1:0]  tail_reg [NCLS];
    logic [CW-1:0]  cnt_reg  [NCLS];
    logic [31:0]    occ_reg  [NCLS];
    logic [SRV_W-1:0] served_reg [NCLS];
    logic [SRV_W-1:0] total_reg;

    // captured transaction
    state_t            state_reg;
    logic              op_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [CLS_W-1:0]  qp_reg;

    // result register
    logic              m_tvalid_reg;
    logic [1:0]        status_reg;
    logic [CLS_W-1:0]  oclass_reg;
    logic [SIZE_W-1:0] osize_reg;

    logic        fifo;
    logic        out_free;
    logic [CW-1:0] cap;
    logic [63:0] div_prod;

    // enqueue check
    logic [CLS_W-1:0] qe;
    logic [32:0]      occ_sum;
    logic [31:0]      q_limit;
    logic             drop;
    logic [AW-1:0]    waddr;
    entry_t           store_wdata;

    // dequeue
    pick_t         pick;
    logic [2:0]    nonempty;
    logic [AW-1:0] raddr;
    logic          store_re;
    logic          store_we;
    entry_t        rdata;
    logic [CLS_W-1:0] qd;
    logic [SIZE_W-1:0] ps;
    logic [SRV_W:0] srv_sum;
    logic [SRV_W:0] tot_sum;

    function automatic logic [AW-1:0] base_of(input logic f, input logic [CLS_W-1:0] q);
        logic [AW-1:0] b;
        b = '0;
        if (!f && q == CLS_W'(1))
        begin
            b = BASE1;
        end
        else if (!f && q == CLS_W'(2))
        begin
            b = BASE2;
        end
        return b;
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p, input logic [CW-1:0] c);
        logic [CW-1:0] n;
        n = CW'(p) + CW'(1);
        return (n == c) ? '0 : n[AW-1:0];
    endfunction

    assign fifo     = (mode_reg == MODE_FIFO);
    assign cap      = fifo ? CAP_FIFO : CAP_CLS;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign div_prod = 64'(limit_reg) * 64'h0000_0000_AAAA_AAAB;

    // a dropped class-three packet looks at queue zero only for indexing
    assign qe      = (fifo || cls_reg == CLS_NONE) ? '0 : cls_reg;
    assign occ_sum = {1'b0, occ_reg[qe]} + 33'(size_reg);
    assign q_limit = fifo ? limit_reg : limit3_reg;
    assign drop    = (cls_reg == CLS_NONE) || (occ_sum > {1'b0, q_limit}) || (cnt_reg[qe] >= cap);
    assign waddr   = base_of(fifo, qe) + tail_reg[qe];
    assign store_we = (state_reg == S_ENQ) && out_free && !drop;
    assign store_wdata = '{cls: cls_reg, size: size_reg};

    always_comb
    begin
        for (int c = 0; c < NCLS; c++)
        begin
            nonempty[c] = (cnt_reg[c] != '0);
        end
    end

    assign qd       = qp_reg;
    assign raddr    = base_of(fifo, pick.q) + head_reg[pick.q];
    assign store_re = (state_reg == S_PICK) && pick.found;
    assign ps       = rdata.size;
    assign srv_sum  = {1'b0, served_reg[rdata.cls == CLS_NONE ? '0 : rdata.cls]} + (SRV_W+1)'(ps);
    assign tot_sum  = {1'b0, total_reg} + (SRV_W+1)'(ps);

    cps_store #(
        .DEPTH (STORE),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (waddr),
        .wdata (store_wdata),
        .re    (store_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    cps_pick u_pick (
        .clk      (clk),
        .load     (state_reg == S_MUL),
        .mode     (mode_reg),
        .nonempty (nonempty),
        .weight   (weight_reg),
        .served   (served_reg),
        .total    (total_reg),
        .pick     (pick)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_FIFO;
            limit_reg     <= '0;
            limit3_reg    <= '0;
            weight_reg[0] <= 8'd128;
            weight_reg[1] <= 8'd77;
            weight_reg[2] <= 8'd51;
            for (int c = 0; c < NCLS; c++)
            begin
                head_reg[c]   <= '0;
                tail_reg[c]   <= '0;
                cnt_reg[c]    <= '0;
                occ_reg[c]    <= '0;
                served_reg[c] <= '0;
            end
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            op_reg       <= OP_ENQ;
            cls_reg      <= '0;
            size_reg     <= '0;
            qp_reg       <= '0;
            status_reg   <= ST_ENQUEUED;
            oclass_reg   <= '0;
            osize_reg    <= '0;
        end
        else
        begin
            limit3_reg <= {1'b0, div_prod[63:33]};
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser[0];
                        cls_reg   <= s_tdata[1:0];
                        size_reg  <= s_tdata[17:2];
                        state_reg <= (s_tuser[0] == OP_DEQ) ? S_MUL : S_ENQ;
                    end
                end
                S_ENQ:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        oclass_reg   <= '0;
                        osize_reg    <= '0;
                        status_reg   <= drop ? ST_DROPPED : ST_ENQUEUED;
                        if (!drop)
                        begin
                            tail_reg[qe] <= wrap_inc(tail_reg[qe], cap);
                            cnt_reg[qe]  <= cnt_reg[qe] + CW'(1);
                            occ_reg[qe]  <= occ_sum[31:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    if (pick.found)
                    begin
                        qp_reg    <= pick.q;
                        state_reg <= S_DATA;
                    end
                    else if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        status_reg   <= ST_EMPTY;
                        oclass_reg   <= '0;
                        osize_reg    <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                S_DATA:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        status_reg   <= ST_DEQUEUED;
                        oclass_reg   <= rdata.cls;
                        osize_reg    <= ps;
                        head_reg[qd] <= wrap_inc(head_reg[qd], cap);
                        cnt_reg[qd]  <= cnt_reg[qd] - CW'(1);
                        occ_reg[qd]  <= (occ_reg[qd] >= 32'(ps)) ? occ_reg[qd] - 32'(ps) : '0;
                        if (rdata.cls != CLS_NONE)
                        begin
                            served_reg[rdata.cls] <= srv_sum[SRV_W] ? '1 : srv_sum[SRV_W-1:0];
                        end
                        total_reg <= tot_sum[SRV_W] ? '1 : tot_sum[SRV_W-1:0];
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // the user must issue configuration writes only while idle; the block itself does not enforce this
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MODE:
                    begin
                        mode_reg <= cfg_data[1:0];
                        for (int c = 0; c < NCLS; c++)
                        begin
                            head_reg[c] <= '0;
                            tail_reg[c] <= '0;
                            cnt_reg[c]  <= '0;
                            occ_reg[c]  <= '0;
                        end
                    end
                    REG_LIMIT:   limit_reg     <= cfg_data;
                    REG_W_AUDIO: weight_reg[0] <= cfg_data[7:0];
                    REG_W_VIDEO: weight_reg[1] <= cfg_data[7:0];
                    REG_W_DATA:  weight_reg[2] <= cfg_data[7:0];
                    default:     ;
                endcase
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'b0, osize_reg, oclass_reg};

    // op_reg records the transaction kind for the checks below
    `CPS_ASSERT(a_data_after_pick, clk, rst_n,
        (state_reg == S_DATA) |-> ($past(state_reg) == S_PICK || $past(state_reg) == S_DATA))
    `CPS_ASSERT(a_deq_path_op, clk, rst_n,
        (state_reg == S_MUL || state_reg == S_PICK || state_reg == S_DATA) |-> (op_reg == OP_DEQ))
    `CPS_ASSERT(a_empty_no_occ, clk, rst_n,
        (cnt_reg[0] != '0 || occ_reg[0] == '0) && (cnt_reg[1] != '0 || occ_reg[1] == '0)
        && (cnt_reg[2] != '0 || occ_reg[2] == '0))
    `CPS_ASSERT(a_fifo_one_queue, clk, rst_n,
        (mode_reg == MODE_FIFO) |-> (cnt_reg[1] == '0 && cnt_reg[2] == '0))
    `CPS_ASSERT(a_class_cap, clk, rst_n,
        (mode_reg != MODE_FIFO) |-> (cnt_reg[0] <= CAP_CLS && cnt_reg[1] <= CAP_CLS
        && cnt_reg[2] <= CAP_CLS))

endmodule

[src/cps_store.sv]
module cps_store #(
    parameter int DEPTH = 192,
    parameter int AW    = 8
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  cps_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output cps_pkg::entry_t rdata
);
    import cps_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/cps_pick.sv]
module cps_pick (
    input  logic                 clk,
    input  logic                 load,
    input  logic [1:0]           mode,
    input  logic [2:0]           nonempty,
    input  logic [7:0]           weight [3],
    input  logic [47:0]          served [3],
    input  logic [47:0]          total,
    output cps_pkg::pick_t       pick
);
    import cps_pkg::*;

    logic signed [OFF_W-1:0] off_reg [NCLS];
    logic [SRV_W-1:0]        t_eff;
    logic [PROD_W-1:0]       prod [NCLS];

    // zero total served counts as two
    assign t_eff = (total == '0) ? SRV_W'(2) : total;

    always_comb
    begin
        for (int c = 0; c < NCLS; c++)
        begin
            prod[c] = PROD_W'(weight[c]) * PROD_W'(t_eff);
        end
    end

    // offset w*T - 256*served, registered
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int c = 0; c < NCLS; c++)
            begin
                off_reg[c] <= $signed({1'b0, prod[c]}) - $signed({1'b0, served[c], 8'b0});
            end
        end
    end

    always_comb
    begin
        logic signed [OFF_W-1:0] best;
        best = '0;
        pick = '{found: 1'b0, q: '0};
        if (mode == MODE_FIFO)
        begin
            pick.found = nonempty[0];
        end
        else if (mode == MODE_WFQ)
        begin
            for (int c = 0; c < NCLS; c++)
            begin
                if (nonempty[c] && (!pick.found || off_reg[c] > best))
                begin
                    pick.found = 1'b1;
                    pick.q     = CLS_W'(c);
                    best       = off_reg[c];
                end
            end
        end
        else
        begin
            for (int c = NCLS - 1; c >= 0; c--)
            begin
                if (nonempty[c])
                begin
                    pick.found = 1'b1;
                    pick.q     = CLS_W'(c);
                end
            end
        end
    end

endmodule

[sim/tb.sv]
module tb;
    import cps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int STORE = NCLS * DEPTH;
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

    // one expected scheduler response
    typedef struct {
        logic [1:0]  status;
        logic [1:0]  cls;
        logic [15:0] size;
    } verdict_t;

    // mirror of the scheduler state plus the queue of pending responses
    class sched_scoreboard;
        logic [1:0]  mode;
        logic [31:0] limit;
        logic [7:0]  weight [NCLS];
        logic [1:0]  st_cls [STORE];
        logic [15:0] st_size [STORE];
        int          heads [NCLS];
        int          tails [NCLS];
        int          counts [NCLS];
        logic [63:0] occ [NCLS];
        logic [47:0] served [NCLS];
        logic [47:0] total;
        verdict_t    pending [$];
        int          errors;

        function new();
            mode = MODE_FIFO;
            limit = 0;
            weight[0] = 8'd128;
            weight[1] = 8'd77;
            weight[2] = 8'd51;
            total = 0;
            errors = 0;
            for (int i = 0; i < NCLS; i++)
                served[i] = 0;
            flush();
        endfunction

        function void flush();
            for (int i = 0; i < NCLS; i++)
            begin
                heads[i] = 0;
                tails[i] = 0;
                counts[i] = 0;
                occ[i] = 0;
            end
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_MODE:
                begin
                    mode = val[1:0];
                    flush();
                end
                REG_LIMIT:   limit = val;
                REG_W_AUDIO: weight[0] = val[7:0];
                REG_W_VIDEO: weight[1] = val[7:0];
                REG_W_DATA:  weight[2] = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [47:0] sat_add(logic [47:0] a, logic [15:0] b);
            logic [48:0] s;
            s = {1'b0, a} + b;
            return s[48] ? SAT48 : s[47:0];
        endfunction

        // work out the response to one accepted transaction
        function void note_input(logic op, logic [1:0] cls, logic [15:0] size);
            verdict_t v;
            bit fifo;
            int cap;
            int q;
            int slot;
            logic [63:0] lim;
            logic signed [63:0] off;
            logic signed [63:0] best;
            logic [63:0] t;
            fifo = (mode == MODE_FIFO);
            cap = fifo ? STORE : DEPTH;
            v.status = ST_ENQUEUED;
            v.cls = 0;
            v.size = 0;
            best = 0;
            if (op == OP_ENQ)
            begin
                if (cls >= NCLS)
                    v.status = ST_DROPPED;
                else
                begin
                    q = fifo ? 0 : cls;
                    lim = fifo ? limit : limit / NCLS;
                    if (occ[q] + size > lim || counts[q] >= cap)
                        v.status = ST_DROPPED;
                    else
                    begin
                        slot = (fifo ? 0 : q * DEPTH) + tails[q];
                        st_cls[slot] = cls;
                        st_size[slot] = size;
                        tails[q] = (tails[q] + 1) % cap;
                        counts[q]++;
                        occ[q] += size;
                    end
                end
            end
            else
            begin
                q = -1;
                if (fifo)
                begin
                    if (counts[0] > 0)
                        q = 0;
                end
                else if (mode == MODE_WFQ)
                begin
                    t = (total == 0) ? 64'd2 : {16'd0, total};
                    for (int c = 0; c < NCLS; c++)
                    begin
                        if (counts[c] == 0)
                            continue;
                        off = $signed(weight[c] * t) - $signed({8'd0, served[c], 8'd0});
                        if (q < 0 || off > best)
                        begin
                            q = c;
                            best = off;
                        end
                    end
                end
                else
                begin
                    for (int c = NCLS - 1; c >= 0; c--)
                        if (counts[c] > 0)
                            q = c;
                end
                if (q < 0)
                    v.status = ST_EMPTY;
                else
                begin
                    slot = (fifo ? 0 : q * DEPTH) + heads[q];
                    v.status = ST_DEQUEUED;
                    v.cls = st_cls[slot];
                    v.size = st_size[slot];
                    heads[q] = (heads[q] + 1) % cap;
                    counts[q]--;
                    occ[q] = (occ[q] >= v.size) ? occ[q] - v.size : 0;
                    served[v.cls] = sat_add(served[v.cls], v.size);
                    total = sat_add(total, v.size);
                end
            end
            pending.push_back(v);
        endfunction

        function void check_result(logic [1:0] status, logic [1:0] cls, logic [15:0] size);
            verdict_t v;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction status=%0d", status);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (status !== v.status)
            begin
                $error("status: expected %0d actual %0d", v.status, status);
                errors++;
            end
            if (cls !== v.cls)
            begin
                $error("out_class: expected %0d actual %0d", v.cls, cls);
                errors++;
            end
            if (size !== v.size)
            begin
                $error("out_size: expected %0d actual %0d", v.size, size);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // out_class[1:0], out_size[17:2], zero fill
    logic [1:0]  m_tuser;   // status[1:0]
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    sched_scoreboard board = new();
    int  hold_off = 0;   // remaining cycles of a forced receiver stall
    bit  stall_on = 1'b1;
    int  burst_left = 0;

    class_packet_scheduler #(.CLASS_DEPTH(DEPTH)) dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: own stall pattern, plus long hold-offs that fill the block
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else if (!stall_on)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 99) == 0)
            stall_on <= !stall_on;
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata[1:0], m_tdata[17:2]);
    end

    // write one register once every transaction in flight has finished
    task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // offer one transaction, with bursty gaps; valid stays high across a burst
    task automatic send_item(logic op, logic [1:0] cls, logic [15:0] size);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {6'd0, size, cls};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(op, cls, size);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // one phase of random traffic; sizes skewed to sometimes fill the limit
    task automatic random_phase(int n, int deq_pct);
        logic [15:0] sz;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: sz = 16'($urandom);
                1: sz = 16'($urandom_range(0, 15));
                default: sz = 16'($urandom_range(0, 2000));
            endcase
            if ($urandom_range(0, 99) < deq_pct)
                send_item(OP_DEQ, 2'($urandom_range(0, 3)), 16'($urandom));
            else
                send_item(OP_ENQ,
                    ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2)), sz);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty dequeue, zero limit drop, class three, extremes
        send_item(OP_DEQ, 2'd0, 16'd0);
        send_item(OP_ENQ, 2'd0, 16'd1);
        write_cfg(REG_LIMIT, 32'hFFFF_FFFF);
        send_item(OP_ENQ, 2'd0, 16'd0);
        send_item(OP_ENQ, 2'd2, 16'hFFFF);
        send_item(OP_ENQ, 2'd1, 16'h5555);
        send_item(OP_ENQ, 2'd3, 16'hAAAA);
        repeat (4) send_item(OP_DEQ, 2'd3, 16'hFFFF);
        drain();

        // strict priority, with mode three as an alias
        write_cfg(REG_MODE, 32'd1);
        send_item(OP_ENQ, 2'd2, 16'd7);
        send_item(OP_ENQ, 2'd1, 16'd8);
        send_item(OP_ENQ, 2'd0, 16'd9);
        repeat (3) send_item(OP_DEQ, 2'd0, 16'd0);
        drain();
        write_cfg(REG_MODE, 32'd3);
        send_item(OP_ENQ, 2'd1, 16'd3);
        send_item(OP_DEQ, 2'd0, 16'd0);
        drain();

        // weighted fair with default weights, then extremes of the weights
        write_cfg(REG_MODE, 32'd2);
        random_phase(250, 45);
        drain();
        write_cfg(REG_W_AUDIO, 32'd0);
        write_cfg(REG_W_VIDEO, 32'd255);
        write_cfg(REG_W_DATA, 32'd255);
        random_phase(250, 45);
        drain();

        // random audio and data weights; small limit forces drops
        write_cfg(REG_LIMIT, 32'd3000);
        write_cfg(REG_W_AUDIO, $urandom_range(0, 255));
        write_cfg(REG_W_DATA, $urandom_range(0, 255));
        random_phase(250, 40);
        drain();

        // fifo with a long receiver hold-off so the block backs up
        write_cfg(REG_MODE, 32'd0);
        write_cfg(REG_LIMIT, 32'd20000);
        hold_off = 300;
        random_phase(250, 35);
        drain();

        // fill the shared store to its entry limit, then empty it
        write_cfg(REG_LIMIT, 32'hFFFF_FFFF);
        random_phase(210, 0);
        random_phase(210, 100);
        drain();

        write_cfg(REG_MODE, 32'd1);
        write_cfg(REG_LIMIT, 32'd0);
        send_item(OP_ENQ, 2'd0, 16'd0);
        write_cfg(REG_LIMIT, 32'd200000);
        random_phase(300, 40);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
